[sv/rsf_pkg.sv]
`default_nettype none
package rsf_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned PIX_W      = 3 * CHAN_W;
  localparam int unsigned SUM_W      = CHAN_W + 3;
  localparam int unsigned PC_W       = WEIGHT_W + CHAN_W;
  localparam int unsigned PN_W       = WEIGHT_W + SUM_W;
  localparam int unsigned DIFF_W     = PN_W + 1;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_CENTER_WEIGHT   = 2'd2;
  localparam logic [1:0] REG_NEIGHBOR_WEIGHT = 2'd3;

  localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH     = 12'd1280;
  localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT    = 12'd960;
  localparam logic [WEIGHT_W-1:0] RST_CENTER_WEIGHT   = 16'd1280;
  localparam logic [WEIGHT_W-1:0] RST_NEIGHBOR_WEIGHT = 16'd128;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic              end_of_frame;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] red_out;
  } result_t;

endpackage
`default_nettype wire

[sv/rsf_out_fifo.sv]
`default_nettype none
module rsf_out_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rsf_pkg::result_t push_data_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output rsf_pkg::result_t      data_o
);

  rsf_pkg::result_t                  store_q [rsf_pkg::FIFO_DEPTH];
  logic [rsf_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [rsf_pkg::FIFO_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [rsf_pkg::FIFO_PTR_W:0]      count_q, count_d;
  logic                              do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + {{rsf_pkg::FIFO_PTR_W{1'b0}}, push_i}
                       - {{rsf_pkg::FIFO_PTR_W{1'b0}}, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < rsf_pkg::FIFO_DEPTH) || do_pop)
    else $error("result queue overflow");

  a_count_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("result queue count lost a word");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> !do_pop)
    else $error("pop from empty result queue");

endmodule
`default_nettype wire

[sv/rgb_sharpen_3x3_filter_core.sv]
// Channel      Direction  Handshake                      Content
// s_axis       in         s_axis_tvalid_i/tready_o       pixel or flush word
// m_axis       out        m_axis_tvalid_o/tready_i       filtered pixel, tlast on frame end
// cfg          in         cfg_we_i                       register index and data
//
// One word is taken each cycle while s_axis_tready_o is high; the result that a word
// releases passes stages 1 to 3 and the result queue, and waits only when the output stalls.
// The row store is one 2048 x 48 bit memory, read when a word is taken and written
// on the next cycle, with forwarding when consecutive words hit the same column.
// Reset is asynchronous and active low; the row store is not cleared.
// A stalled output fills an eight-word result queue; input stalls only when
// every queue slot is claimed by a word already in flight.
`default_nettype none
module rgb_sharpen_3x3_filter_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // red_in, green_in, blue_in
  input  wire logic        s_axis_tuser_i,   // kind
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // red_out, green_out, blue_out
  output logic             m_axis_tlast_o,   // end_of_frame
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int unsigned CW   = rsf_pkg::COL_W;
  localparam int unsigned SW   = rsf_pkg::SIZE_W;
  localparam int unsigned PW   = rsf_pkg::PIX_W;
  localparam int unsigned CHW  = rsf_pkg::CHAN_W;
  localparam int unsigned SUMW = rsf_pkg::SUM_W;
  localparam int unsigned PCW  = rsf_pkg::PC_W;
  localparam int unsigned PNW  = rsf_pkg::PN_W;
  localparam int unsigned DW   = rsf_pkg::DIFF_W;
  localparam int unsigned QW   = SW + 2;

  // Configuration registers.
  logic [SW-1:0]                 width_cfg_q, height_cfg_q;
  logic [rsf_pkg::WEIGHT_W-1:0]  cw_q, nw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q  <= rsf_pkg::RST_FRAME_WIDTH;
      height_cfg_q <= rsf_pkg::RST_FRAME_HEIGHT;
      cw_q         <= rsf_pkg::RST_CENTER_WEIGHT;
      nw_q         <= rsf_pkg::RST_NEIGHBOR_WEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsf_pkg::REG_FRAME_WIDTH:     width_cfg_q  <= cfg_wdata_i[SW-1:0];
        rsf_pkg::REG_FRAME_HEIGHT:    height_cfg_q <= cfg_wdata_i[SW-1:0];
        rsf_pkg::REG_CENTER_WEIGHT:   cw_q         <= cfg_wdata_i;
        rsf_pkg::REG_NEIGHBOR_WEIGHT: nw_q         <= cfg_wdata_i;
        default:                      cw_q         <= cw_q;
      endcase
    end
  end

  // Position and pending count.
  logic [CW-1:0]  col_q, col_d;
  logic [SW-1:0]  row_q, row_d;
  logic [SW-1:0]  owed_q, owed_d;
  logic [rsf_pkg::FIFO_PTR_W:0] used_q, used_d;

  logic           s_acc, m_acc, flush, take, emit;
  logic [SW-1:0]  w, h;
  logic [SW:0]    w_plus1;
  logic           col_zero;
  logic [SW-1:0]  qc, col_inc;
  logic signed [QW-1:0] qr_raw, qr, h_s;
  logic           border, eof, wrap;
  logic [SW:0]    row_inc;
  logic [PW-1:0]  px;

  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign flush = (s_axis_tuser_i == rsf_pkg::KIND_FLUSH);
  assign take  = s_acc && !(flush && owed_q == '0);
  assign s_axis_tready_o = (used_q < rsf_pkg::FIFO_DEPTH);

  always_comb begin
    if (width_cfg_q < SW'(3)) begin
      w = SW'(3);
    end else if (width_cfg_q > SW'(rsf_pkg::MAX_WIDTH)) begin
      w = SW'(rsf_pkg::MAX_WIDTH);
    end else begin
      w = width_cfg_q;
    end
    h        = (height_cfg_q < SW'(3)) ? SW'(3) : height_cfg_q;
    w_plus1  = {1'b0, w} + 1'b1;
    emit     = flush || ({1'b0, owed_q} >= w_plus1);
    col_zero = (col_q == '0);
    qc       = col_zero ? w - 1'b1 : SW'(col_q) - 1'b1;
    h_s      = $signed({2'b00, h});
    qr_raw   = $signed({2'b00, row_q}) - (col_zero ? QW'(2) : QW'(1));
    qr       = (qr_raw < 0) ? qr_raw + h_s : qr_raw;
    border   = (qr <= 0) || (qr >= h_s - 1) || (qc == '0) || (qc >= w - 1'b1);
    eof      = (qr == h_s - 1) && (qc == w - 1'b1);
    px       = flush ? '0 : {s_axis_tdata_i[7:0], s_axis_tdata_i[15:8],
                             s_axis_tdata_i[23:16]};

    if (flush) begin
      owed_d = owed_q - 1'b1;
    end else if (emit) begin
      owed_d = w_plus1[SW-1:0];
    end else begin
      owed_d = owed_q + 1'b1;
    end

    col_inc = SW'(col_q) + 1'b1;
    wrap    = (col_inc >= w);
    row_inc = {1'b0, row_q} + 1'b1;
    col_d   = wrap ? '0 : col_inc[CW-1:0];
    if (wrap) begin
      row_d = (row_inc >= {1'b0, h}) ? '0 : row_inc[SW-1:0];
    end else begin
      row_d = row_q;
    end
    if (flush && owed_q == SW'(1)) begin
      col_d = '0;
      row_d = '0;
    end
  end

  assign m_acc  = m_axis_tvalid_o && m_axis_tready_i;
  assign used_d = used_q + {{rsf_pkg::FIFO_PTR_W{1'b0}}, (take && emit)}
                         - {{rsf_pkg::FIFO_PTR_W{1'b0}}, m_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      owed_q <= '0;
      used_q <= '0;
    end else begin
      used_q <= used_d;
      if (take) begin
        col_q  <= col_d;
        row_q  <= row_d;
        owed_q <= owed_d;
      end
    end
  end

  // Stage 1: row store data returns, window shifts, neighbour sums.
  logic              s1_valid_q, s1_emit_q, s1_border_q, s1_eof_q;
  logic [CW-1:0]     s1_addr_q;
  logic [PW-1:0]     s1_px_q;
  logic              fwd_q;
  logic [2*PW-1:0]   fwd_data_q;
  logic [2*PW-1:0]   mem_rd_q;
  logic [2*PW-1:0]   row_mem [rsf_pkg::MAX_WIDTH];
  logic [2*PW-1:0]   rd, wr_data;
  logic [PW-1:0]     t, a;
  logic [PW-1:0]     win_q [6];
  logic [SUMW-1:0]   sum [3];

  assign rd      = fwd_q ? fwd_data_q : mem_rd_q;
  assign t       = rd[2*PW-1:PW];
  assign a       = rd[PW-1:0];
  assign wr_data = {a, s1_px_q};

  always_ff @(posedge clk_i) begin
    if (take) begin
      mem_rd_q <= row_mem[col_q];
    end
    if (s1_valid_q) begin
      row_mem[s1_addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      s1_valid_q <= take;
      if (take) begin
        fwd_q <= s1_valid_q && (s1_addr_q == col_q);
      end
      if (s1_valid_q) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= t;
        win_q[4] <= a;
        win_q[5] <= s1_px_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_addr_q   <= col_q;
      s1_px_q     <= px;
      s1_emit_q   <= emit;
      s1_border_q <= border;
      s1_eof_q    <= eof;
      fwd_data_q  <= wr_data;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SUMW'(win_q[0][CHW*(2-k) +: CHW]) + SUMW'(win_q[1][CHW*(2-k) +: CHW])
             + SUMW'(win_q[2][CHW*(2-k) +: CHW]) + SUMW'(win_q[3][CHW*(2-k) +: CHW])
             + SUMW'(win_q[5][CHW*(2-k) +: CHW]) + SUMW'(t[CHW*(2-k) +: CHW])
             + SUMW'(a[CHW*(2-k) +: CHW])        + SUMW'(s1_px_q[CHW*(2-k) +: CHW]);
    end
  end

  // Stage 2: products.
  logic              s2_valid_q, s2_border_q, s2_eof_q;
  logic [PW-1:0]     s2_centre_q;
  logic [SUMW-1:0]   s2_sum_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_emit_q) begin
      s2_centre_q <= win_q[4];
      s2_border_q <= s1_border_q;
      s2_eof_q    <= s1_eof_q;
      for (int k = 0; k < 3; k++) begin
        s2_sum_q[k] <= sum[k];
      end
    end
  end

  // Stage 3: difference, scaling and clamp.
  logic              s3_valid_q, s3_border_q, s3_eof_q;
  logic [PW-1:0]     s3_centre_q;
  logic [PCW-1:0]    s3_pc_q [3];
  logic [PNW-1:0]    s3_pn_q [3];
  logic signed [DW-1:0] diff [3];
  logic [DW-9:0]     scaled [3];
  logic [CHW-1:0]    chan_res [3];
  rsf_pkg::result_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_centre_q <= s2_centre_q;
      s3_border_q <= s2_border_q;
      s3_eof_q    <= s2_eof_q;
      for (int k = 0; k < 3; k++) begin
        s3_pc_q[k] <= PCW'(cw_q) * PCW'(s2_centre_q[CHW*(2-k) +: CHW]);
        s3_pn_q[k] <= PNW'(nw_q) * PNW'(s2_sum_q[k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]   = $signed(DW'(s3_pc_q[k])) - $signed(DW'(s3_pn_q[k]));
      scaled[k] = diff[k][DW-1:8];
      if (s3_border_q) begin
        chan_res[k] = s3_centre_q[CHW*(2-k) +: CHW];
      end else if (diff[k] <= 0) begin
        chan_res[k] = '0;
      end else if (scaled[k] > (DW-8)'(255)) begin
        chan_res[k] = '1;
      end else begin
        chan_res[k] = scaled[k][CHW-1:0];
      end
    end
    res.red_out      = chan_res[0];
    res.green_out    = chan_res[1];
    res.blue_out     = chan_res[2];
    res.end_of_frame = s3_eof_q;
  end

  rsf_pkg::result_t out_word;

  rsf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_valid_q),
    .push_data_i (res),
    .pop_i       (m_axis_tready_i),
    .valid_o     (m_axis_tvalid_o),
    .data_o      (out_word)
  );

  assign m_axis_tdata_o = {out_word.blue_out, out_word.green_out, out_word.red_out};
  assign m_axis_tlast_o = out_word.end_of_frame;

  a_credit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= rsf_pkg::FIFO_DEPTH)
    else $error("more results in flight than queue slots");

  a_stage_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> $past(s2_valid_q))
    else $error("result stage valid without preceding product stage");

  a_forward_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && s1_valid_q && s1_addr_q == col_q) |=> fwd_q && s1_valid_q)
    else $error("same-column word missed forwarding");

endmodule
`default_nettype wire
